### rtl/kvt_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// kvt_pkg: shared types and constants for the key-value table
// Field widths, default sizes, controller states and memory control groups.
// ----------------------------------------------------------------------------
package kvt_pkg;

  localparam int KVT_ENTRIES    = 16;
  localparam int KVT_KEY_BITS   = 64;
  localparam int KVT_VALUE_BITS = 32;

  localparam int KVT_ACTION_W = 1;
  localparam int KVT_KEY_W    = 64;
  localparam int KVT_VALUE_W  = 32;

  localparam logic KVT_ACT_ADD    = 1'b0;
  localparam logic KVT_ACT_LOOKUP = 1'b1;

  localparam logic KVT_STATUS_OK   = 1'b0;
  localparam logic KVT_STATUS_FULL = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } kvt_state_t;

  typedef struct packed {
    logic rd_en;
    logic wr_en;
  } kvt_mem_ctl_t;

  typedef struct packed {
    logic done;
    logic hit;
  } kvt_scan_sts_t;

endpackage
`default_nettype wire

### rtl/key_value_table_insert_lookup.sv
`default_nettype none
// ----------------------------------------------------------------------------
// key_value_table_insert_lookup: bounded key-value table with linear search
// Input channel (in_valid/in_stall) carries an action, a key and a value.
// An add overwrites the value of an equal key or fills the next free entry;
// a full table returns status=1 and stores nothing. A lookup returns found
// and the stored value, or found=0 and value 0. Entries are never removed.
// Result channel (out_valid/out_stall) returns one result per request.
// Sequence: the request is taken, the search reads one stored key per cycle
// from the entry memory (its single read port sets the pace), the last key
// read is compared in the cycle after that read, and the write-back loads
// the result register. Only after that is the next request accepted.
// Reset empties the table at once through the fill count; no clearing pass.
// A stalled result holds in the output register; the next request is
// accepted, but its write-back waits until the held result is taken.
// ----------------------------------------------------------------------------
module key_value_table_insert_lookup #(
  parameter int ENTRIES    = kvt_pkg::KVT_ENTRIES,
  parameter int KEY_BITS   = kvt_pkg::KVT_KEY_BITS,
  parameter int VALUE_BITS = kvt_pkg::KVT_VALUE_BITS
) (
  input  wire                                clk,
  input  wire                                rst_n,
  input  wire                                in_valid,
  output logic                               in_stall,
  input  wire  [kvt_pkg::KVT_ACTION_W-1:0]   in_action,
  input  wire  [kvt_pkg::KVT_KEY_W-1:0]      in_key,
  input  wire  [kvt_pkg::KVT_VALUE_W-1:0]    in_value,
  output logic                               out_valid,
  input  wire                                out_stall,
  output logic                               out_status,
  output logic                               out_found,
  output logic [kvt_pkg::KVT_VALUE_W-1:0]    out_value_out
);
  import kvt_pkg::*;

  localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CW = $clog2(ENTRIES + 1);

  kvt_state_t              state_r, state_nxt;
  logic [CW-1:0]           fill_r, fill_nxt;
  logic                    act_r;
  logic [KEY_BITS-1:0]     key_r;
  logic [VALUE_BITS-1:0]   val_r;
  logic                    hit_r;
  logic [AW-1:0]           hit_addr_r;
  logic [VALUE_BITS-1:0]   hit_val_r;
  logic                    out_valid_r, out_valid_nxt;
  logic                    out_status_r;
  logic                    out_found_r;
  logic [KVT_VALUE_W-1:0]  out_value_r;

  logic                    in_xfer;
  logic                    scan_start;
  logic                    out_load;
  logic                    table_full;
  logic                    wr_req;
  logic [63:0]             in_value_wide;
  logic [63:0]             hit_val_wide;

  kvt_mem_ctl_t            mem_ctl;
  logic [AW-1:0]           mem_wr_addr;
  logic [AW-1:0]           rd_addr;
  logic [KEY_BITS-1:0]     rd_key;
  logic [VALUE_BITS-1:0]   rd_value;
  logic                    scan_rd_en;
  kvt_scan_sts_t           scan_sts;
  logic [AW-1:0]           scan_hit_addr;
  logic [VALUE_BITS-1:0]   scan_hit_value;

  assign in_xfer       = in_valid && !in_stall;
  assign table_full    = (fill_r == CW'(ENTRIES));
  assign wr_req        = (act_r == KVT_ACT_ADD) && (hit_r || !table_full);
  assign in_value_wide = {32'b0, in_value};
  assign hit_val_wide  = 64'(hit_val_r);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_sts.done) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    in_stall       = 1'b1;
    scan_start     = 1'b0;
    out_load       = 1'b0;
    mem_ctl.wr_en  = 1'b0;
    mem_ctl.rd_en  = scan_rd_en;
    unique case (state_r)
      ST_IDLE: begin
        in_stall   = 1'b0;
        scan_start = in_valid;
      end
      ST_SCAN: begin
      end
      ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_load      = 1'b1;
          mem_ctl.wr_en = wr_req;
        end
      end
      default: begin
      end
    endcase
  end

  assign mem_wr_addr   = hit_r ? hit_addr_r : fill_r[AW-1:0];

  always_comb begin
    fill_nxt = fill_r;
    if (out_load && (act_r == KVT_ACT_ADD) && !hit_r && !table_full) begin
      fill_nxt = CW'(fill_r + 1'b1);
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // request and search result holding
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      act_r <= in_action;
      key_r <= in_key[KEY_BITS-1:0];
      val_r <= in_value_wide[VALUE_BITS-1:0];
    end
    if (state_r == ST_SCAN && scan_sts.done) begin
      hit_r      <= scan_sts.hit;
      hit_addr_r <= scan_hit_addr;
      hit_val_r  <= scan_hit_value;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_found_r <= hit_r;
      if (act_r == KVT_ACT_ADD) begin
        out_status_r <= (!hit_r && table_full) ? KVT_STATUS_FULL : KVT_STATUS_OK;
        out_value_r  <= '0;
      end else begin
        out_status_r <= KVT_STATUS_OK;
        out_value_r  <= hit_r ? hit_val_wide[KVT_VALUE_W-1:0] : '0;
      end
    end
  end

  assign out_valid     = out_valid_r;
  assign out_status    = out_status_r;
  assign out_found     = out_found_r;
  assign out_value_out = out_value_r;

  kvt_scan #(
    .ENTRIES    (ENTRIES),
    .KEY_BITS   (KEY_BITS),
    .VALUE_BITS (VALUE_BITS)
  ) u_scan (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (scan_start),
    .key       (key_r),
    .fill      (fill_r),
    .rd_key    (rd_key),
    .rd_value  (rd_value),
    .rd_en     (scan_rd_en),
    .rd_addr   (rd_addr),
    .sts       (scan_sts),
    .hit_addr  (scan_hit_addr),
    .hit_value (scan_hit_value)
  );

  kvt_mem #(
    .ENTRIES    (ENTRIES),
    .KEY_BITS   (KEY_BITS),
    .VALUE_BITS (VALUE_BITS)
  ) u_mem (
    .clk      (clk),
    .ctl      (mem_ctl),
    .rd_addr  (rd_addr),
    .wr_addr  (mem_wr_addr),
    .wr_key   (key_r),
    .wr_value (val_r),
    .rd_key   (rd_key),
    .rd_value (rd_value)
  );

  // fill count never passes the table size
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= CW'(ENTRIES))
    else $error("fill count above table size");

  // search reads and write-back never share a cycle
  a_no_rw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(mem_ctl.rd_en && mem_ctl.wr_en))
    else $error("memory read and write in the same cycle");

  // search finishes only while the controller waits for it
  a_done_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    scan_sts.done |-> state_r == ST_SCAN)
    else $error("search done outside scan state");

  // a full status never comes with a hit
  a_full_no_hit: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == KVT_STATUS_FULL) |-> !out_found)
    else $error("table full reported on a hit");

endmodule
`default_nettype wire

### rtl/kvt_mem.sv
`default_nettype none
// ----------------------------------------------------------------------------
// kvt_mem: entry storage
// Key and value arrays with one write port and one registered read port.
// ----------------------------------------------------------------------------
module kvt_mem #(
  parameter int ENTRIES    = kvt_pkg::KVT_ENTRIES,
  parameter int KEY_BITS   = kvt_pkg::KVT_KEY_BITS,
  parameter int VALUE_BITS = kvt_pkg::KVT_VALUE_BITS,
  localparam int AW        = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
  input  wire                       clk,
  input  kvt_pkg::kvt_mem_ctl_t     ctl,
  input  wire  [AW-1:0]             rd_addr,
  input  wire  [AW-1:0]             wr_addr,
  input  wire  [KEY_BITS-1:0]       wr_key,
  input  wire  [VALUE_BITS-1:0]     wr_value,
  output logic [KEY_BITS-1:0]       rd_key,
  output logic [VALUE_BITS-1:0]     rd_value
);
  import kvt_pkg::*;

  logic [KEY_BITS-1:0]   key_mem [ENTRIES];
  logic [VALUE_BITS-1:0] val_mem [ENTRIES];

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      key_mem[wr_addr] <= wr_key;
      val_mem[wr_addr] <= wr_value;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.rd_en) begin
      rd_key   <= key_mem[rd_addr];
      rd_value <= val_mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

### rtl/kvt_scan.sv
`default_nettype none
// ----------------------------------------------------------------------------
// kvt_scan: linear key search
// Walks the filled entries one read per cycle and compares each key in the
// cycle after its read; stops at the first match or after the last filled entry.
// ----------------------------------------------------------------------------
module kvt_scan #(
  parameter int ENTRIES    = kvt_pkg::KVT_ENTRIES,
  parameter int KEY_BITS   = kvt_pkg::KVT_KEY_BITS,
  parameter int VALUE_BITS = kvt_pkg::KVT_VALUE_BITS,
  localparam int AW        = (ENTRIES > 1) ? $clog2(ENTRIES) : 1,
  localparam int CW        = $clog2(ENTRIES + 1)
) (
  input  wire                        clk,
  input  wire                        rst_n,
  input  wire                        start,
  input  wire  [KEY_BITS-1:0]        key,
  input  wire  [CW-1:0]              fill,
  input  wire  [KEY_BITS-1:0]        rd_key,
  input  wire  [VALUE_BITS-1:0]      rd_value,
  output logic                       rd_en,
  output logic [AW-1:0]              rd_addr,
  output kvt_pkg::kvt_scan_sts_t     sts,
  output logic [AW-1:0]              hit_addr,
  output logic [VALUE_BITS-1:0]      hit_value
);
  import kvt_pkg::*;

  logic          busy_r, busy_nxt;
  logic          pend_r, pend_nxt;
  logic [CW-1:0] ptr_r, ptr_nxt;
  logic [AW-1:0] pend_addr_r;
  logic          hit;

  assign hit       = busy_r && pend_r && (rd_key == key);
  assign rd_en     = busy_r && (ptr_r != fill) && !hit;
  assign rd_addr   = ptr_r[AW-1:0];
  assign sts.hit   = hit;
  assign sts.done  = busy_r && (hit || (ptr_r == fill));
  assign hit_addr  = pend_addr_r;
  assign hit_value = rd_value;

  always_comb begin
    busy_nxt = busy_r;
    pend_nxt = rd_en;
    ptr_nxt  = ptr_r;
    if (start) begin
      busy_nxt = 1'b1;
      pend_nxt = 1'b0;
      ptr_nxt  = '0;
    end else begin
      if (rd_en) begin
        ptr_nxt = CW'(ptr_r + 1'b1);
      end
      if (sts.done) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      pend_r <= 1'b0;
      ptr_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      pend_r <= pend_nxt;
      ptr_r  <= ptr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_addr_r <= rd_addr;
  end

endmodule
`default_nettype wire

### tb/sv/key_value_table_insert_lookup_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// key_value_table_insert_lookup_tb: self-checking bench for the key-value table
// Walks a short directed table (empty lookups, extreme keys and values,
// overwrite, fill to the last entry, add on a full table), then sends random
// adds and lookups over stored keys, near misses and fresh keys. A local
// copy of the table predicts every result the directed table does not give,
// and each result transfer is checked field by field against the oldest
// expected result. The sender idles and the receiver stalls at several rates,
// including a long receiver hold-off and pauses until all results are back.
// ----------------------------------------------------------------------------
module key_value_table_insert_lookup_tb;
  import kvt_pkg::*;

  localparam int CYCLE_LIMIT   = 400000;
  localparam int HOLD_CYCLES   = 300;
  localparam int RANDOM_ITEMS  = 225;
  localparam int SETTLE_CYCLES = 40;
  localparam int DIR_ROWS      = 25;

  typedef struct packed {
    logic                   status;
    logic                   found;
    logic [KVT_VALUE_W-1:0] value;
  } kv_result_t;

  typedef struct packed {
    logic                   act;
    logic [KVT_KEY_W-1:0]   key;
    logic [KVT_VALUE_W-1:0] val;
    logic                   typed;
    kv_result_t             want;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [KVT_ACTION_W-1:0] in_action = KVT_ACT_ADD;
  logic [KVT_KEY_W-1:0] in_key = '0;
  logic [KVT_VALUE_W-1:0] in_value = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic out_status;
  logic out_found;
  logic [KVT_VALUE_W-1:0] out_value_out;

  // side data that travels with the item on the input port
  logic drv_typed = 1'b0;
  kv_result_t drv_want = '0;

  logic tbl_valid [KVT_ENTRIES];
  logic [KVT_KEY_W-1:0] tbl_key [KVT_ENTRIES];
  logic [KVT_VALUE_W-1:0] tbl_value [KVT_ENTRIES];
  kv_result_t pending_replies [$];

  int error_count = 0;
  int cycle_count = 0;
  int send_idle_pct = 0;
  int stall_pct = 0;
  int hold_reqs = 0;
  int hold_seen = 0;
  int hold_left = 0;

  dir_row_t dir_rows [DIR_ROWS] = '{
    '{KVT_ACT_LOOKUP, 64'h0, 32'h0, 1'b1, '{KVT_STATUS_OK, 1'b0, 32'h0}},
    '{KVT_ACT_ADD, 64'h0, 32'h1234_5678, 1'b1, '{KVT_STATUS_OK, 1'b0, 32'h0}},
    '{KVT_ACT_ADD, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF, 1'b1,
      '{KVT_STATUS_OK, 1'b0, 32'h0}},
    '{KVT_ACT_LOOKUP, 64'hFFFF_FFFF_FFFF_FFFF, 32'h0, 1'b1,
      '{KVT_STATUS_OK, 1'b1, 32'hFFFF_FFFF}},
    '{KVT_ACT_LOOKUP, 64'h0, 32'hFFFF_FFFF, 1'b1, '{KVT_STATUS_OK, 1'b1, 32'h1234_5678}},
    '{KVT_ACT_ADD, 64'h0, 32'h0, 1'b1, '{KVT_STATUS_OK, 1'b1, 32'h0}},
    '{KVT_ACT_LOOKUP, 64'h0, 32'h0, 1'b1, '{KVT_STATUS_OK, 1'b1, 32'h0}},
    '{KVT_ACT_LOOKUP, 64'h8000_0000_0000_0000, 32'h0, 1'b1, '{KVT_STATUS_OK, 1'b0, 32'h0}},
    '{KVT_ACT_LOOKUP, 64'hFFFF_FFFF_FFFF_FFFE, 32'h0, 1'b1, '{KVT_STATUS_OK, 1'b0, 32'h0}},
    '{KVT_ACT_ADD, 64'h8000_0000_0000_0000, 32'h8000_0001, 1'b0, '0},
    '{KVT_ACT_ADD, 64'h0000_0000_0000_0001, 32'h0000_0011, 1'b0, '0},
    '{KVT_ACT_ADD, 64'h0000_0001_0000_0000, 32'h0000_0022, 1'b0, '0},
    '{KVT_ACT_ADD, 64'h5555_5555_5555_5555, 32'h5555_5555, 1'b0, '0},
    '{KVT_ACT_ADD, 64'hAAAA_AAAA_AAAA_AAAA, 32'hAAAA_AAAA, 1'b0, '0},
    '{KVT_ACT_ADD, 64'h0000_0000_FFFF_FFFF, 32'h0000_0044, 1'b0, '0},
    '{KVT_ACT_ADD, 64'hFFFF_FFFF_0000_0000, 32'h0000_0055, 1'b0, '0},
    '{KVT_ACT_ADD, 64'h7FFF_FFFF_FFFF_FFFF, 32'h7FFF_FFFF, 1'b0, '0},
    '{KVT_ACT_ADD, 64'h0123_0000_0000_0000, 32'h0000_0077, 1'b0, '0},
    '{KVT_ACT_ADD, 64'h00FF_00FF_00FF_00FF, 32'h0000_0088, 1'b0, '0},
    '{KVT_ACT_ADD, 64'hFF00_FF00_FF00_FF00, 32'h0000_0099, 1'b0, '0},
    '{KVT_ACT_ADD, 64'h0F0F_0F0F_0F0F_0F0F, 32'h0000_00AA, 1'b0, '0},
    '{KVT_ACT_ADD, 64'hF0F0_F0F0_F0F0_F0F0, 32'h0000_00BB, 1'b0, '0},
    '{KVT_ACT_ADD, 64'hDEAD_BEEF_CAFE_F00D, 32'h0000_00CC, 1'b0, '0},
    '{KVT_ACT_ADD, 64'h0123_4567_89AB_CDEF, 32'h0000_00DD, 1'b1,
      '{KVT_STATUS_FULL, 1'b0, 32'h0}},
    '{KVT_ACT_LOOKUP, 64'h0123_4567_89AB_CDEF, 32'h0, 1'b1, '{KVT_STATUS_OK, 1'b0, 32'h0}}
  };

  key_value_table_insert_lookup dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_action     (in_action),
    .in_key        (in_key),
    .in_value      (in_value),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_status    (out_status),
    .out_found     (out_found),
    .out_value_out (out_value_out)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  function automatic kv_result_t table_apply(input logic act,
                                             input logic [KVT_KEY_W-1:0] key,
                                             input logic [KVT_VALUE_W-1:0] val);
    kv_result_t res;
    int hit;
    int free_idx;
    res = '{status: KVT_STATUS_OK, found: 1'b0, value: '0};
    hit = -1;
    free_idx = -1;
    for (int i = 0; i < KVT_ENTRIES; i++) begin
      if (hit < 0 && tbl_valid[i] && tbl_key[i] == key) hit = i;
      if (free_idx < 0 && !tbl_valid[i]) free_idx = i;
    end
    if (act == KVT_ACT_ADD) begin
      if (hit >= 0) begin
        tbl_value[hit] = val;
        res.found = 1'b1;
      end else if (free_idx < 0) begin
        res.status = KVT_STATUS_FULL;
      end else begin
        tbl_valid[free_idx] = 1'b1;
        tbl_key[free_idx] = key;
        tbl_value[free_idx] = val;
      end
    end else if (hit >= 0) begin
      res.found = 1'b1;
      res.value = tbl_value[hit];
    end
    return res;
  endfunction

  task automatic report_error(input string what);
    error_count++;
    if (error_count <= 40) $display("%0t ns: mismatch: %s", $time, what);
  endtask

  // accepted requests are predicted, result transfers are checked
  always @(posedge clk) begin
    kv_result_t want;
    kv_result_t got;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        want = table_apply(in_action, in_key, in_value);
        if (drv_typed) want = drv_want;
        pending_replies.push_back(want);
      end
      if (out_valid && !out_stall) begin
        got = '{status: out_status, found: out_found, value: out_value_out};
        if (pending_replies.size() == 0) begin
          report_error("result transfer with no request outstanding");
        end else begin
          want = pending_replies.pop_front();
          if (got.status !== want.status)
            report_error($sformatf("status got %b want %b", got.status, want.status));
          if (got.found !== want.found)
            report_error($sformatf("found got %b want %b", got.found, want.found));
          if (got.value !== want.value)
            report_error($sformatf("value_out got %h want %h", got.value, want.value));
        end
      end
    end
  end

  // receiver: long hold-off on request, otherwise random stalls
  always @(negedge clk) begin
    if (hold_seen != hold_reqs) begin
      hold_seen = hold_reqs;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles", CYCLE_LIMIT);
    $display("FAIL key_value_table_insert_lookup");
    $finish;
  end

  task automatic send_item(input logic act, input logic [KVT_KEY_W-1:0] key,
                           input logic [KVT_VALUE_W-1:0] val, input logic typed,
                           input kv_result_t want);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_action <= act;
    in_key <= key;
    in_value <= val;
    drv_typed <= typed;
    drv_want <= want;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic send_random();
    logic act;
    logic [KVT_KEY_W-1:0] key;
    logic [KVT_VALUE_W-1:0] val;
    int pick;
    int idx;
    act = $urandom_range(1) ? KVT_ACT_LOOKUP : KVT_ACT_ADD;
    pick = $urandom_range(99);
    idx = $urandom_range(KVT_ENTRIES - 1);
    key = {$urandom, $urandom};
    if (pick < 80 && tbl_valid[idx]) begin
      key = tbl_key[idx];
      // near miss: one bit off a stored key
      if (pick >= 68) key = key ^ (64'd1 << $urandom_range(KVT_KEY_W - 1));
    end
    pick = $urandom_range(9);
    if (pick == 0) val = '0;
    else if (pick == 1) val = '1;
    else val = $urandom;
    send_item(act, key, val, 1'b0, '0);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk);
  endtask

  initial begin
    for (int i = 0; i < KVT_ENTRIES; i++) begin
      tbl_valid[i] = 1'b0;
      tbl_key[i] = '0;
      tbl_value[i] = '0;
    end
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (int r = 0; r < DIR_ROWS; r++) begin
      send_item(dir_rows[r].act, dir_rows[r].key, dir_rows[r].val,
                dir_rows[r].typed, dir_rows[r].want);
    end

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 0;
          stall_pct = 0;
        end
        1: begin
          send_idle_pct = 61;
          stall_pct = 0;
        end
        2: begin
          send_idle_pct = 0;
          stall_pct = 61;
        end
        default: begin
          send_idle_pct = 30;
          stall_pct = 30;
        end
      endcase
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
        if (phase == 0 && n == 80) hold_reqs++;
        if (phase == 2 && n == 100) wait_drained();
        send_random();
      end
      wait_drained();
    end

    @(negedge clk);
    in_valid <= 1'b0;
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("PASS key_value_table_insert_lookup");
    end else begin
      $display("FAIL key_value_table_insert_lookup");
    end
    $finish;
  end

endmodule

### files.f
rtl/kvt_pkg.sv
rtl/kvt_mem.sv
rtl/kvt_scan.sv
rtl/key_value_table_insert_lookup.sv
tb/sv/key_value_table_insert_lookup_tb.sv
